// ===== src/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// Link timer table scheduler package
// Shared constants, operation and event codes, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Table geometry.
  localparam int LINKS         = 8;
  localparam int TIMER_KINDS   = 4;
  localparam int TICKS_PER_SEC = 10;

  localparam int LINK_W    = 3;
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = LINK_W + KIND_W;
  localparam int N_ENTRIES = LINKS * TIMER_KINDS;
  localparam int CNT_W     = $clog2(N_ENTRIES + 1);
  localparam int CD_W      = $clog2(TICKS_PER_SEC + 1);

  // Field widths.
  localparam int OP_W    = 2;
  localparam int SECS_W  = 16;
  localparam int TIME_W  = 20;
  localparam int EVENT_W = 3;

  localparam logic [TIME_W-1:0] MAX20   = 20'hFFFFF;
  localparam logic [TIME_W-1:0] ARM_MAX = 20'hFFFFE;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ARM     = 2'd0;
  localparam logic [OP_W-1:0] OP_ENROL   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // Result event codes; expiry of kind k is EV_EXPIRY_BASE + k.
  localparam logic [EVENT_W-1:0] EV_STATUS      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_TX_TICK     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_EXPIRY_BASE = 3'd2;

  // Result of one pass through the shared decrement and compare unit.
  typedef struct packed {
    logic [TIME_W-1:0] val;
    logic              expired;
    logic [TIME_W-1:0] best;
  } lts_unit_res_t;

  localparam int ARM_PROD_W = SECS_W + 10;
  localparam int TENTH_W    = TIME_W + 4;

  // Reciprocal of TICKS_PER_SEC, rounded up, exact for any TENTH_W-bit dividend.
  localparam int RECIP_SH = TENTH_W + $clog2(TICKS_PER_SEC);
  localparam int RECIP_W  = TENTH_W + 1;
  localparam int RPROD_W  = TENTH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC));

  // Seconds to base ticks, saturated to the largest armable count.
  function automatic logic [TIME_W-1:0] arm_ticks(input logic [SECS_W-1:0] secs);
    logic [ARM_PROD_W-1:0] prod;
    prod = ARM_PROD_W'(secs) * ARM_PROD_W'(TICKS_PER_SEC);
    if (prod > ARM_PROD_W'(ARM_MAX)) begin
      return ARM_MAX;
    end
    return prod[TIME_W-1:0];
  endfunction

  // Base ticks to tenths of a second, rounded half up and saturated.
  function automatic logic [TIME_W-1:0] ticks_to_tenths(input logic [TIME_W-1:0] t);
    logic [TENTH_W-1:0] num;
    logic [RPROD_W-1:0] prod;
    logic [TENTH_W-1:0] q;
    num  = TENTH_W'(t) * TENTH_W'(10) + TENTH_W'(TICKS_PER_SEC / 2);
    // Divide by TICKS_PER_SEC through the reciprocal and a shift.
    prod = RPROD_W'(num) * RPROD_W'(RECIP_M);
    q    = TENTH_W'(prod >> RECIP_SH);
    if (q > TENTH_W'(MAX20)) begin
      return MAX20;
    end
    return q[TIME_W-1:0];
  endfunction

endpackage

// ===== src/lts_table.sv =====
// ----------------------------------------------------------------------------
// Link timer table
// Timer memory with one write and one registered read port; a per-entry valid
// bit makes never-written entries read as zero (disarmed) after reset.
// ----------------------------------------------------------------------------
module lts_table
  import lts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TIME_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0]    mem [N_ENTRIES];
  logic [N_ENTRIES-1:0] valid_r;
  logic [TIME_W-1:0]    rd_q_r;
  logic                 rd_vld_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Valid bits clear on reset and mark written entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== src/lts_unit.sv =====
// ----------------------------------------------------------------------------
// Link timer shared unit
// Decrements one timer entry when advancing and folds it into the running
// minimum of armed entries.
// ----------------------------------------------------------------------------
module lts_unit
  import lts_pkg::*;
(
  input  logic [TIME_W-1:0] val,
  input  logic [TIME_W-1:0] best,
  input  logic              dec_en,
  output lts_unit_res_t     res
);

  logic              armed;
  logic [TIME_W-1:0] new_val;

  // Decrement an armed entry; it expires when it steps from one to zero.
  assign armed   = (val != '0);
  assign new_val = (dec_en && armed) ? (val - TIME_W'(1)) : val;

  // Minimum of the armed values seen so far.
  always_comb begin
    res.val     = new_val;
    res.expired = dec_en && (val == TIME_W'(1));
    res.best    = best;
    if ((new_val != '0) && (new_val < best)) begin
      res.best = new_val;
    end
  end

endmodule

// ===== src/link_timer_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// Link timer table scheduler
// Per-link one-shot timers and a shared one-second tick, stepped by a small
// sequencer around one table memory and one decrement/compare unit.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  input     start / busy       in_operation, in_link_index, in_timer_kind,
//                               in_seconds, in_enable
//  result    out_valid strobe   out_event_kind, out_event_link,
//                               out_remaining_tenths, out_soonest_ticks,
//                               out_last
//
//  Every item walks the 32 table entries through the single memory read port
//  before its status result; a read adds one extra memory read and an
//  advance that fires the tick adds a walk over the eight links first.
//  busy is high from the cycle after a start transaction until the cycle in
//  which the status result (out_last high) is shown; results come one per
//  cycle at most.
//  Reset is synchronous and active low and leaves all timers disarmed.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module link_timer_table_scheduler
  import lts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [LINK_W-1:0]  in_link_index,
  input  logic [KIND_W-1:0]  in_timer_kind,
  input  logic [SECS_W-1:0]  in_seconds,
  input  logic               in_enable,
  output logic               out_valid,
  output logic [EVENT_W-1:0] out_event_kind,
  output logic [LINK_W-1:0]  out_event_link,
  output logic [TIME_W-1:0]  out_remaining_tenths,
  output logic [TIME_W-1:0]  out_soonest_ticks,
  output logic               out_last
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACT  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [LINK_W-1:0]  link_r, link_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [SECS_W-1:0]  secs_r, secs_nxt;
  logic               en_r, en_nxt;
  logic [LINKS-1:0]   member_r, member_nxt;
  logic [CD_W-1:0]    cd_r, cd_nxt;
  logic [LINK_W-1:0]  lnk_r, lnk_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  raddr_r, raddr_nxt;
  logic [TIME_W-1:0]  best_r, best_nxt;
  logic [TIME_W-1:0]  tenths_r, tenths_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0] out_kind_r, out_kind_nxt;
  logic [LINK_W-1:0]  out_link_r, out_link_nxt;
  logic [TIME_W-1:0]  out_tenths_r, out_tenths_nxt;
  logic [TIME_W-1:0]  out_soon_r, out_soon_nxt;
  logic               out_last_r, out_last_nxt;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [TIME_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TIME_W-1:0]  rd_data;
  lts_unit_res_t      unit_res;

  logic               valid_link;
  logic               valid_timer;
  logic [ADDR_W-1:0]  entry_addr;
  logic [LINKS-1:0]   member_clr;
  logic [TIME_W-1:0]  soon_final;

  // Timer memory and shared unit.
  lts_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lts_unit u_unit (
    .val    (rd_data),
    .best   (best_r),
    .dec_en (op_r == OP_ADVANCE),
    .res    (unit_res)
  );

  // Decoded fields of the current transaction.
  assign valid_link  = (int'(link_r) < LINKS);
  assign valid_timer = valid_link && (int'(kind_r) < TIMER_KINDS);
  assign entry_addr  = {kind_r, link_r};
  assign member_clr  = member_r & ~(LINKS'(1) << link_r);

  // The tick countdown counts toward the soonest expiry too.
  assign soon_final = ((cd_r != '0) && (TIME_W'(cd_r) < best_r)) ? TIME_W'(cd_r) : best_r;

  // Sequencer next-state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    link_nxt       = link_r;
    kind_nxt       = kind_r;
    secs_nxt       = secs_r;
    en_nxt         = en_r;
    member_nxt     = member_r;
    cd_nxt         = cd_r;
    lnk_nxt        = lnk_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    raddr_nxt      = raddr_r;
    best_nxt       = best_r;
    tenths_nxt     = tenths_r;
    wr_en          = 1'b0;
    wr_addr        = raddr_r;
    wr_data        = unit_res.val;
    rd_addr        = cnt_r[ADDR_W-1:0];
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_link_nxt   = out_link_r;
    out_tenths_nxt = out_tenths_r;
    out_soon_nxt   = out_soon_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_operation;
          link_nxt   = in_link_index;
          kind_nxt   = in_timer_kind;
          secs_nxt   = in_seconds;
          en_nxt     = in_enable;
          best_nxt   = MAX20;
          tenths_nxt = '0;
          state_nxt  = S_ACT;
        end
      end

      S_ACT: begin
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SCAN;
        unique case (op_r)
          OP_ARM: begin
            if (valid_timer) begin
              wr_en   = 1'b1;
              wr_addr = entry_addr;
              wr_data = arm_ticks(secs_r);
            end
          end
          OP_ENROL: begin
            if (valid_link) begin
              if (en_r) begin
                if (member_r == '0) begin
                  cd_nxt = CD_W'(TICKS_PER_SEC);
                end
                member_nxt = member_r | (LINKS'(1) << link_r);
              end else begin
                member_nxt = member_clr;
                if (member_clr == '0) begin
                  cd_nxt = '0;
                end
              end
            end
          end
          OP_ADVANCE: begin
            if (cd_r == CD_W'(1)) begin
              cd_nxt    = CD_W'(TICKS_PER_SEC);
              lnk_nxt   = '0;
              state_nxt = S_TICK;
            end else if (cd_r != '0) begin
              cd_nxt = cd_r - CD_W'(1);
            end
          end
          OP_READ: begin
            rd_addr   = entry_addr;
            state_nxt = S_RD;
          end
          default: ;
        endcase
      end

      S_RD: begin
        if (valid_timer) begin
          tenths_nxt = ticks_to_tenths(rd_data);
        end
        state_nxt = S_SCAN;
      end

      // Walk the links and raise a tx tick for every enrolled one.
      S_TICK: begin
        if (member_r[lnk_r]) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = EV_TX_TICK;
          out_link_nxt   = lnk_r;
          out_tenths_nxt = '0;
          out_soon_nxt   = '0;
          out_last_nxt   = 1'b0;
        end
        if (lnk_r == LINK_W'(LINKS - 1)) begin
          state_nxt = S_SCAN;
        end else begin
          lnk_nxt = lnk_r + LINK_W'(1);
        end
      end

      // Pipelined table walk: issue one read, process the previous one.
      S_SCAN: begin
        if (cnt_r < CNT_W'(N_ENTRIES)) begin
          rd_addr   = cnt_r[ADDR_W-1:0];
          raddr_nxt = cnt_r[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          best_nxt = unit_res.best;
          if ((op_r == OP_ADVANCE) && (rd_data != '0)) begin
            wr_en   = 1'b1;
            wr_addr = raddr_r;
            wr_data = unit_res.val;
          end
          if (unit_res.expired) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = EV_EXPIRY_BASE + EVENT_W'(raddr_r[ADDR_W-1:LINK_W]);
            out_link_nxt   = raddr_r[LINK_W-1:0];
            out_tenths_nxt = '0;
            out_soon_nxt   = '0;
            out_last_nxt   = 1'b0;
          end
          if (raddr_r == ADDR_W'(N_ENTRIES - 1)) begin
            state_nxt = S_STAT;
          end
        end
      end

      S_STAT: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = EV_STATUS;
        out_link_nxt   = '0;
        out_tenths_nxt = tenths_r;
        out_soon_nxt   = soon_final;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      member_r    <= '0;
      cd_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      member_r    <= member_nxt;
      cd_r        <= cd_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    link_r       <= link_nxt;
    kind_r       <= kind_nxt;
    secs_r       <= secs_nxt;
    en_r         <= en_nxt;
    lnk_r        <= lnk_nxt;
    cnt_r        <= cnt_nxt;
    raddr_r      <= raddr_nxt;
    best_r       <= best_nxt;
    tenths_r     <= tenths_nxt;
    out_kind_r   <= out_kind_nxt;
    out_link_r   <= out_link_nxt;
    out_tenths_r <= out_tenths_nxt;
    out_soon_r   <= out_soon_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_event_kind       = out_kind_r;
  assign out_event_link       = out_link_r;
  assign out_remaining_tenths = out_tenths_r;
  assign out_soonest_ticks    = out_soon_r;
  assign out_last             = out_last_r;

  // The status result closes the transaction.
  a_status_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high when status result is shown");

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a start transaction");

  // Event results report no soonest expiry.
  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_soonest_ticks == '0 && out_event_kind != EV_STATUS))
    else $error("event result with status fields");

  // Between transactions the tick countdown runs exactly when a link is enrolled.
  a_countdown_members: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((cd_r == '0) == (member_r == '0)))
    else $error("tick countdown disagrees with enrolment");

  // The countdown never exceeds one second.
  a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
    cd_r <= CD_W'(TICKS_PER_SEC))
    else $error("tick countdown out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Link timer table scheduler testbench
// Drives arm, enrol, advance and read commands through the start/busy port
// and checks every tx tick, expiry and status result against a timer table
// kept inside the bench. A short directed sequence is followed by random
// traffic, including a burst that fires all timers and ticks at once, under
// three levels of sender idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  // One command as it appears on the input ports.
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [LINK_W-1:0] link;
    logic [KIND_W-1:0] kind;
    logic [SECS_W-1:0] secs;
    logic              en;
  } timer_cmd_t;

  // One result as it appears on the output ports.
  typedef struct {
    logic [EVENT_W-1:0] ev_kind;
    logic [LINK_W-1:0]  ev_link;
    logic [TIME_W-1:0]  tenths;
    logic [TIME_W-1:0]  soonest;
    logic               is_last;
  } timer_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_operation = '0;
  logic [LINK_W-1:0]  in_link_index = '0;
  logic [KIND_W-1:0]  in_timer_kind = '0;
  logic [SECS_W-1:0]  in_seconds = '0;
  logic               in_enable = 1'b0;
  logic               out_valid;
  logic [EVENT_W-1:0] out_event_kind;
  logic [LINK_W-1:0]  out_event_link;
  logic [TIME_W-1:0]  out_remaining_tenths;
  logic [TIME_W-1:0]  out_soonest_ticks;
  logic               out_last;

  // Timer table mirror kept by the predictor.
  logic [TIME_W-1:0] timer_left [N_ENTRIES];
  logic [LINKS-1:0]  tick_enrolled;
  int unsigned       tick_count;

  timer_cmd_t   pending_cmds[$];
  timer_event_t expected_results[$];
  timer_cmd_t   on_ports;

  int unsigned sender_idle_pct = 31;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          advance_count = 0;
  int          results_seen = 0;
  int          tx_ticks_seen = 0;
  int          expiries_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  link_timer_table_scheduler dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_link_index        (in_link_index),
    .in_timer_kind        (in_timer_kind),
    .in_seconds           (in_seconds),
    .in_enable            (in_enable),
    .out_valid            (out_valid),
    .out_event_kind       (out_event_kind),
    .out_event_link       (out_event_link),
    .out_remaining_tenths (out_remaining_tenths),
    .out_soonest_ticks    (out_soonest_ticks),
    .out_last             (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one command to the table mirror and queues the results it causes.
  function automatic void step_link_timers(input timer_cmd_t c);
    int unsigned       idx;
    logic [25:0]       ticks;
    logic [23:0]       tenths_wide;
    logic [TIME_W-1:0] tenths;
    logic [TIME_W-1:0] best;
    bit                valid_link;
    bit                valid_timer;
    valid_link  = int'(c.link) < LINKS;
    valid_timer = valid_link && int'(c.kind) < TIMER_KINDS;
    idx = int'(c.kind) * LINKS + int'(c.link);
    tenths = '0;
    case (c.op)
      OP_ARM: begin
        if (valid_timer) begin
          ticks = 26'(c.secs) * 26'(TICKS_PER_SEC);
          timer_left[idx] = (ticks > 26'(ARM_MAX)) ? ARM_MAX : ticks[TIME_W-1:0];
        end
      end
      OP_ENROL: begin
        if (valid_link) begin
          if (c.en) begin
            // The first member starts the one-second countdown.
            if (tick_enrolled == '0) tick_count = TICKS_PER_SEC;
            tick_enrolled[c.link] = 1'b1;
          end else begin
            tick_enrolled[c.link] = 1'b0;
            if (tick_enrolled == '0) tick_count = 0;
          end
        end
      end
      OP_ADVANCE: begin
        // Tick events come first, then expiries grouped by kind and link.
        if (tick_count != 0) begin
          tick_count--;
          if (tick_count == 0) begin
            for (int l = 0; l < LINKS; l++) begin
              if (tick_enrolled[l]) begin
                expected_results.push_back('{ev_kind: EV_TX_TICK, ev_link: LINK_W'(l),
                                             tenths: '0, soonest: '0, is_last: 1'b0});
              end
            end
            tick_count = TICKS_PER_SEC;
          end
        end
        for (int k = 0; k < TIMER_KINDS; k++) begin
          for (int l = 0; l < LINKS; l++) begin
            if (timer_left[k * LINKS + l] != 0) begin
              timer_left[k * LINKS + l]--;
              if (timer_left[k * LINKS + l] == 0) begin
                expected_results.push_back('{ev_kind: EVENT_W'(EV_EXPIRY_BASE + k),
                                             ev_link: LINK_W'(l), tenths: '0,
                                             soonest: '0, is_last: 1'b0});
              end
            end
          end
        end
      end
      OP_READ: begin
        if (valid_timer) begin
          tenths_wide = (24'(timer_left[idx]) * 24'd10 + 24'(TICKS_PER_SEC / 2))
                        / 24'(TICKS_PER_SEC);
          tenths = (tenths_wide > 24'(MAX20)) ? MAX20 : tenths_wide[TIME_W-1:0];
        end
      end
    endcase
    // The soonest expiry includes the tick countdown.
    best = MAX20;
    if (tick_count != 0 && TIME_W'(tick_count) < best) best = TIME_W'(tick_count);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (timer_left[i] != 0 && timer_left[i] < best) best = timer_left[i];
    end
    expected_results.push_back('{ev_kind: EV_STATUS, ev_link: '0, tenths: tenths,
                                 soonest: best, is_last: 1'b1});
  endfunction

  function automatic void add_cmd(input logic [OP_W-1:0] op, input int link, input int kind,
                                  input int secs, input bit en);
    pending_cmds.push_back('{op: op, link: LINK_W'(link), kind: KIND_W'(kind),
                             secs: SECS_W'(secs), en: en});
    queued_count++;
  endfunction

  // Random traffic: mostly short arms and advances so that timers expire.
  function automatic void add_random_cmds(input int count);
    timer_cmd_t  c;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      c.link = LINK_W'($urandom);
      c.kind = KIND_W'($urandom);
      c.secs = SECS_W'($urandom);
      c.en   = 1'($urandom);
      pick   = $urandom_range(99);
      if (pick < 45) begin
        c.op = OP_ADVANCE;
      end else if (pick < 65) begin
        c.op = OP_ARM;
        pick = $urandom_range(9);
        if (pick < 7) c.secs = SECS_W'($urandom_range(1, 3));
        else if (pick == 7) c.secs = '0;
      end else if (pick < 80) begin
        c.op = OP_ENROL;
      end else begin
        c.op = OP_READ;
      end
      pending_cmds.push_back(c);
      queued_count++;
    end
  endfunction

  // Presents queued commands; a held start stays up until busy lets it in.
  always @(posedge clk) begin : command_driver
    timer_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        step_link_timers(on_ports);
        accepted_count++;
        if (on_ports.op == OP_ADVANCE) advance_count++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_cmds.pop_front();
          on_ports = nxt;
          start <= 1'b1;
          in_operation <= nxt.op;
          in_link_index <= nxt.link;
          in_timer_kind <= nxt.kind;
          in_seconds <= nxt.secs;
          in_enable <= nxt.en;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Each strobed result is matched against the oldest expected result.
  always @(posedge clk) begin : result_monitor
    timer_event_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_event_kind == EV_TX_TICK) tx_ticks_seen++;
      else if (out_event_kind >= EV_EXPIRY_BASE) expiries_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d link %0d",
                                  out_event_kind, out_event_link));
      end else begin
        want = expected_results.pop_front();
        if (out_event_kind !== want.ev_kind)
          report_mismatch($sformatf("event_kind got %0d want %0d",
                                    out_event_kind, want.ev_kind));
        if (out_event_link !== want.ev_link)
          report_mismatch($sformatf("event_link got %0d want %0d",
                                    out_event_link, want.ev_link));
        if (out_remaining_tenths !== want.tenths)
          report_mismatch($sformatf("remaining_tenths got %0d want %0d",
                                    out_remaining_tenths, want.tenths));
        if (out_soonest_ticks !== want.soonest)
          report_mismatch($sformatf("soonest_ticks got %0d want %0d",
                                    out_soonest_ticks, want.soonest));
        if (out_last !== want.is_last)
          report_mismatch($sformatf("last got %0d want %0d", out_last, want.is_last));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("[link_timer_table_scheduler] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) timer_left[i] = '0;
    tick_enrolled = '0;
    tick_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: disarmed read, empty advance, field extremes, enrolment rules,
    // a tick coinciding with expiries, removal of the last member, disarm.
    sender_idle_pct = 31;
    add_cmd(OP_READ, 0, 0, 0, 1'b0);
    add_cmd(OP_ADVANCE, 0, 0, 0, 1'b0);
    add_cmd(OP_ARM, 0, 0, 1, 1'b0);
    add_cmd(OP_ARM, 7, 3, 65535, 1'b1);
    add_cmd(OP_ARM, 3, 1, 2, 1'b0);
    add_cmd(OP_ARM, 5, 2, 1, 1'b0);
    add_cmd(OP_READ, 7, 3, 0, 1'b0);
    add_cmd(OP_ENROL, 2, 0, 0, 1'b1);
    add_cmd(OP_ENROL, 2, 0, 0, 1'b1);
    add_cmd(OP_ENROL, 6, 0, 0, 1'b1);
    for (int n = 0; n < 10; n++) add_cmd(OP_ADVANCE, n % 8, n % 4, 0, 1'b0);
    add_cmd(OP_ENROL, 2, 0, 0, 1'b0);
    add_cmd(OP_ENROL, 6, 0, 0, 1'b0);
    add_cmd(OP_ARM, 3, 1, 0, 1'b0);
    add_cmd(OP_READ, 3, 1, 0, 1'b0);
    add_random_cmds(100);
    while (accepted_count != queued_count) @(negedge clk);

    sender_idle_pct = 52;
    add_random_cmds(60);
    while (accepted_count != queued_count) @(negedge clk);

    // Burst: every timer and every link fire on the same advance.
    sender_idle_pct = 0;
    for (int l = 0; l < LINKS; l++) add_cmd(OP_ENROL, l, 0, 0, 1'b0);
    for (int k = 0; k < TIMER_KINDS; k++) begin
      for (int l = 0; l < LINKS; l++) add_cmd(OP_ARM, l, k, 1, 1'b0);
    end
    for (int l = 0; l < LINKS; l++) add_cmd(OP_ENROL, l, 0, 0, 1'b1);
    for (int n = 0; n < TICKS_PER_SEC; n++) add_cmd(OP_ADVANCE, 0, 0, 0, 1'b0);
    add_random_cmds(40);
    while (accepted_count != queued_count) @(negedge clk);

    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d time advances) under three sender idle levels.",
             accepted_count, advance_count);
    $display("Checked %0d results, %0d tx ticks and %0d expiries among them.",
             results_seen, tx_ticks_seen, expiries_seen);
    if (mismatches == 0) begin
      $display("[link_timer_table_scheduler] OK");
    end else begin
      $display("[link_timer_table_scheduler] ERROR");
    end
    $finish;
  end

endmodule
